### rtl/cbsm_pkg.sv
package cbsm_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SUM_W      = ADDR_W + 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = 8 * NUM_CH;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PIXELS);

  localparam logic [1:0] ACT_BACKGROUND = 2'd0;
  localparam logic [1:0] ACT_FRAME      = 2'd1;
  localparam logic [1:0] ACT_DRAIN      = 2'd2;
  localparam logic [1:0] ACT_IGNORED    = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_BG    = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  typedef logic [7:0]              chan_t;
  typedef logic signed [8:0]       offset_t;
  typedef logic [SUM_W-1:0]        sum_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [PIX_W-1:0]        pix_word_t;

  typedef struct packed {
    logic [1:0] action;
    chan_t      blue;
    chan_t      green;
    chan_t      red;
    logic       end_of_image;
  } pixel_t;

  typedef struct packed {
    chan_t      diff_blue;
    chan_t      diff_green;
    chan_t      diff_red;
    logic       last_pixel;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic   go;
    logic   enable;
    count_t count;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_SETUP,
    DV_STEP,
    DV_ROUND
  } div_state_t;

endpackage

### rtl/cbsm_ram.sv
module cbsm_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              write_en,
  input  logic [ADDR_W-1:0] write_addr,
  input  logic [DATA_W-1:0] write_data,
  input  logic              read_en,
  input  logic [ADDR_W-1:0] read_addr,
  output logic [DATA_W-1:0] read_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[write_addr] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (read_en) begin
      read_data <= mem[read_addr];
    end
  end

endmodule

### rtl/cbsm_div.sv
module cbsm_div
  import cbsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  input  sum_t     bg_sums [NUM_CH],
  input  sum_t     fr_sums [NUM_CH],
  output div_rsp_t rsp,
  output offset_t  offsets [NUM_CH]
);

  div_state_t state, state_next;

  logic [1:0]   ch;
  logic [2:0]   step;
  logic         neg;
  logic         en;
  chan_t        mag_lo;
  count_t       rem;
  chan_t        quo;

  logic [SUM_W:0]   num;
  logic [SUM_W:0]   mag_full;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   den_ext;
  logic [CNT_W:0]   twice_rem;
  logic             round_up;
  logic [8:0]       quo_round;
  offset_t          quo_signed;

  // The quotient never exceeds 255 because every channel value does not, so
  // eight restoring steps on the low byte cover the whole magnitude.
  always_comb begin
    num       = {1'b0, bg_sums[ch]} - {1'b0, fr_sums[ch]};
    mag_full  = num[SUM_W] ? (~num + 1'b1) : num;
    den_ext   = {1'b0, req.count};
    trial     = {rem, mag_lo[7]};
    twice_rem = {rem, 1'b0};
    round_up  = (twice_rem > den_ext) || ((twice_rem == den_ext) && quo[0]);
    quo_round = {1'b0, quo} + {8'd0, round_up};
    quo_signed = neg ? offset_t'(-quo_round) : offset_t'(quo_round);
  end

  always_comb begin
    state_next = state;
    rsp.busy   = (state != DV_IDLE);
    rsp.done   = 1'b0;
    unique case (state)
      DV_IDLE: begin
        if (req.go) begin
          state_next = DV_SETUP;
        end
      end
      DV_SETUP: begin
        state_next = DV_STEP;
      end
      DV_STEP: begin
        if (step == 3'd7) begin
          state_next = DV_ROUND;
        end
      end
      DV_ROUND: begin
        if (ch == 2'(NUM_CH - 1)) begin
          state_next = DV_IDLE;
          rsp.done   = 1'b1;
        end else begin
          state_next = DV_SETUP;
        end
      end
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        offsets[i] <= '0;
      end
    end else if (state == DV_ROUND) begin
      offsets[ch] <= en ? quo_signed : '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DV_IDLE: begin
        ch <= '0;
        en <= req.enable;
      end
      DV_SETUP: begin
        neg    <= num[SUM_W];
        rem    <= {1'b0, mag_full[SUM_W-1:8]};
        mag_lo <= mag_full[7:0];
        quo    <= '0;
        step   <= '0;
      end
      DV_STEP: begin
        if (trial >= den_ext) begin
          rem <= count_t'(trial - den_ext);
          quo <= {quo[6:0], 1'b1};
        end else begin
          rem <= trial[CNT_W-1:0];
          quo <= {quo[6:0], 1'b0};
        end
        mag_lo <= {mag_lo[6:0], 1'b0};
        step   <= step + 3'd1;
      end
      DV_ROUND: begin
        ch <= ch + 2'd1;
      end
      default: ch <= '0;
    endcase
  end

endmodule

### rtl/color_background_subtract_meancorr_top.sv
// Background subtraction with mean correction for 8-bit BGR pixels. Load a
// background (action 0) and a frame (action 1) at one pixel per clock while
// pixel_stall is low, each ending with end_of_image; both images live in
// on-chip simple dual-port RAMs of MAX_PIXELS entries, and no clearing pass
// follows reset. Closing a frame, or closing a background while a frame is
// closed, starts the offset divider, which holds pixel_stall high through
// the start request and then, per channel, a setup state, eight restoring
// quotient steps and a rounding state. Drains (action 2) run at one per
// clock while the divider is idle and the result side takes transfers; a
// result passes through the RAM read register and then the output register.
module color_background_subtract_meancorr_top
  import cbsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_write_enable,
  input  logic    cfg_write_data,
  input  logic    pixel_valid,
  output logic    pixel_stall,
  input  pixel_t  pixel,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic    correct_mean;
  count_t  bg_count, bg_count_next;
  count_t  fr_count, fr_count_next;
  sum_t    bg_sums [NUM_CH];
  sum_t    bg_sums_next [NUM_CH];
  sum_t    fr_sums [NUM_CH];
  sum_t    fr_sums_next [NUM_CH];
  count_t  read_pointer, read_pointer_next;
  logic    bg_valid, bg_valid_next;
  logic    bg_closed, bg_closed_next;
  logic    fr_closed, fr_closed_next;
  logic    div_go, div_go_next;
  logic    div_enable, div_enable_next;

  logic    rd_pend, rd_pend_next;
  logic    pend_last;
  logic [1:0] pend_status;
  offset_t pend_offsets [NUM_CH];

  div_req_t  dreq;
  div_rsp_t  drsp;
  offset_t   offsets [NUM_CH];

  logic      accept;
  logic      can_load;
  logic      drain_ok;
  logic      bg_write, fr_write;
  pix_word_t pix_word;
  pix_word_t bg_data, fr_data;
  count_t    bg_base, fr_base;
  chan_t     chan_in [NUM_CH];
  result_t   result_next;

  assign chan_in[0] = pixel.blue;
  assign chan_in[1] = pixel.green;
  assign chan_in[2] = pixel.red;
  assign pix_word   = {pixel.red, pixel.green, pixel.blue};

  assign can_load    = !result_valid || !result_stall;
  assign pixel_stall = div_go || drsp.busy || (rd_pend && !can_load);
  assign accept      = pixel_valid && !pixel_stall;

  // A load after its image was closed starts that image over.
  assign bg_base  = bg_closed ? '0 : bg_count;
  assign fr_base  = fr_closed ? '0 : fr_count;
  assign bg_write = accept && (pixel.action == ACT_BACKGROUND) && (bg_base < MAX_COUNT);
  assign fr_write = accept && (pixel.action == ACT_FRAME) && (fr_base < MAX_COUNT);
  assign drain_ok = fr_closed && (read_pointer < fr_count);

  always_comb begin
    bg_count_next     = bg_count;
    fr_count_next     = fr_count;
    bg_sums_next      = bg_sums;
    fr_sums_next      = fr_sums;
    read_pointer_next = read_pointer;
    bg_valid_next     = bg_valid;
    bg_closed_next    = bg_closed;
    fr_closed_next    = fr_closed;
    div_go_next       = 1'b0;
    rd_pend_next      = rd_pend && !can_load;
    if (accept) begin
      unique case (pixel.action)
        ACT_BACKGROUND: begin
          bg_valid_next  = 1'b0;
          bg_closed_next = 1'b0;
          bg_count_next  = bg_base;
          if (bg_closed) begin
            for (int c = 0; c < NUM_CH; c++) begin
              bg_sums_next[c] = '0;
            end
          end
          if (bg_base < MAX_COUNT) begin
            for (int c = 0; c < NUM_CH; c++) begin
              bg_sums_next[c] = bg_sums_next[c] + sum_t'(chan_in[c]);
            end
            bg_count_next = bg_base + count_t'(1);
          end
          if (pixel.end_of_image) begin
            bg_closed_next = 1'b1;
            bg_valid_next  = 1'b1;
            div_go_next    = fr_closed;
          end
        end
        ACT_FRAME: begin
          fr_closed_next    = 1'b0;
          read_pointer_next = '0;
          fr_count_next     = fr_base;
          if (fr_closed) begin
            for (int c = 0; c < NUM_CH; c++) begin
              fr_sums_next[c] = '0;
            end
          end
          if (fr_base < MAX_COUNT) begin
            for (int c = 0; c < NUM_CH; c++) begin
              fr_sums_next[c] = fr_sums_next[c] + sum_t'(chan_in[c]);
            end
            fr_count_next = fr_base + count_t'(1);
          end
          if (pixel.end_of_image) begin
            fr_closed_next = 1'b1;
            div_go_next    = 1'b1;
          end
        end
        ACT_DRAIN: begin
          if (drain_ok) begin
            read_pointer_next = read_pointer + count_t'(1);
            rd_pend_next      = 1'b1;
          end
        end
        default: ;
      endcase
    end
    div_enable_next = correct_mean && bg_valid_next && (fr_count_next != '0) &&
                      (fr_count_next == bg_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      correct_mean <= 1'b1;
      bg_count     <= '0;
      fr_count     <= '0;
      read_pointer <= '0;
      bg_valid     <= 1'b0;
      bg_closed    <= 1'b0;
      fr_closed    <= 1'b0;
      div_go       <= 1'b0;
      div_enable   <= 1'b0;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        bg_sums[c] <= '0;
        fr_sums[c] <= '0;
      end
    end else begin
      if (cfg_write_enable) begin
        correct_mean <= cfg_write_data;
      end
      bg_count     <= bg_count_next;
      fr_count     <= fr_count_next;
      read_pointer <= read_pointer_next;
      bg_valid     <= bg_valid_next;
      bg_closed    <= bg_closed_next;
      fr_closed    <= fr_closed_next;
      div_go       <= div_go_next;
      div_enable   <= div_enable_next;
      rd_pend      <= rd_pend_next;
      bg_sums      <= bg_sums_next;
      fr_sums      <= fr_sums_next;
      if (rd_pend && can_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Everything a drain result needs besides the pixels is captured with the
  // transfer, so a load taken in the next cycle cannot disturb it.
  always_ff @(posedge clk) begin
    if (accept && (pixel.action == ACT_DRAIN) && drain_ok) begin
      pend_last <= (read_pointer + count_t'(1)) == fr_count;
      if (!bg_valid) begin
        pend_status <= STATUS_NO_BG;
      end else if (bg_count != fr_count) begin
        pend_status <= STATUS_MISMATCH;
      end else begin
        pend_status <= STATUS_OK;
      end
      pend_offsets <= offsets;
    end
  end

  always_comb begin
    logic signed [9:0] corr;
    chan_t             fv;
    chan_t             bv;
    chan_t             sat;
    chan_t             diff [NUM_CH];
    for (int c = 0; c < NUM_CH; c++) begin
      fv   = fr_data[8*c +: 8];
      bv   = bg_data[8*c +: 8];
      corr = $signed({2'b00, fv}) + 10'(pend_offsets[c]);
      if (corr < 0) begin
        sat = 8'd0;
      end else if (corr > 10'sd255) begin
        sat = 8'd255;
      end else begin
        sat = corr[7:0];
      end
      diff[c] = (pend_status != STATUS_OK) ? 8'd0 : ((sat > bv) ? (sat - bv) : (bv - sat));
    end
    result_next.diff_blue  = diff[0];
    result_next.diff_green = diff[1];
    result_next.diff_red   = diff[2];
    result_next.last_pixel = pend_last;
    result_next.status     = pend_status;
  end

  always_ff @(posedge clk) begin
    if (rd_pend && can_load) begin
      result <= result_next;
    end
  end

  assign dreq.go     = div_go;
  assign dreq.enable = div_enable;
  assign dreq.count  = fr_count;

  cbsm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (dreq),
    .bg_sums (bg_sums),
    .fr_sums (fr_sums),
    .rsp     (drsp),
    .offsets (offsets)
  );

  cbsm_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (PIX_W)
  ) u_bg_ram (
    .clk        (clk),
    .write_en   (bg_write),
    .write_addr (bg_base[ADDR_W-1:0]),
    .write_data (pix_word),
    .read_en    (accept && (pixel.action == ACT_DRAIN) && drain_ok),
    .read_addr  (read_pointer[ADDR_W-1:0]),
    .read_data  (bg_data)
  );

  cbsm_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (PIX_W)
  ) u_fr_ram (
    .clk        (clk),
    .write_en   (fr_write),
    .write_addr (fr_base[ADDR_W-1:0]),
    .write_data (pix_word),
    .read_en    (accept && (pixel.action == ACT_DRAIN) && drain_ok),
    .read_addr  (read_pointer[ADDR_W-1:0]),
    .read_data  (fr_data)
  );

endmodule
